### rtl/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_D = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT   = 1'd1;

  // Ids at or above this value are triangles
  localparam logic [7:0] ID_TRI_MIN = 8'd10;

  // Zone codes
  localparam logic [1:0] ZONE_OUT  = 2'd0;
  localparam logic [1:0] ZONE_IN   = 2'd1;
  localparam logic [1:0] ZONE_NONE = 2'd2;

  // Width of the exact area sums
  localparam int unsigned AREA_W = 38;

  typedef struct packed {
    logic               kind;
    logic [3:0]         entry;
    logic [7:0]         region_id;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } in_item_t;

  typedef struct packed {
    logic [7:0] found_region;
    logic [1:0] zone;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         id;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    logic signed [15:0] bz;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_TEST,
    ST_MUL,
    ST_CMP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic       load_wr;
    logic       start;
    logic       rd_en;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_en;
    logic [1:0] acc_sel;
    logic       set_found;
    logic       set_zone;
    logic       publish;
  } cmd_t;

  typedef struct packed {
    logic is_box;
    logic box_hit;
    logic zone_hit;
    logic tri_hit;
    logic out_busy;
  } status_t;

endpackage

### rtl/point_region_classifier_top.sv
`timescale 1ns / 1ps

// Point region classifier.
// Input channel (in_valid_i/in_ready_o, in_item_i) takes two kinds of item:
// a load writes one region table entry and gives no result; a point is
// tested in order against entries 0 .. min(region_count, MAX_REGIONS)-1 and
// gives exactly one result (found_region, zone) on the output channel
// (out_valid_o/out_ready_i). Configuration writes (cfg_valid_i, cfg_index_i,
// cfg_data_i) are always taken and must only be issued while the block is idle.
// A load is written to the table as it is taken. A point is held on entry,
// then each entry tested passes through table read and compare for a box, or
// table read, decode, the multiply steps through the shared pair of 17x17
// multipliers and area compare for a triangle; the result then goes into the
// output register. The sequencer walks one entry at a time, so one point is
// in flight at once.
// The result sits in an output register; the next item is taken while it
// waits. If the receiver stalls, a second finished point holds until the
// register frees. Reset clears control state and configuration; table
// contents are undefined until loaded.
module point_region_classifier_top import prc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned FRAC_BITS   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  cmd_t          cmd;
  status_t       status;
  logic [IW-1:0] addr;
  logic          z_in;

  assign cfg_ready_o = 1'b1;

  prc_ctrl #(
    .MAX_REGIONS(MAX_REGIONS),
    .IW(IW),
    .CW(CW)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_kind_i  (in_item_i.kind),
    .in_ready_o,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .status_i   (status),
    .z_in_i     (z_in),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  prc_datapath #(
    .MAX_REGIONS(MAX_REGIONS),
    .FRAC_BITS(FRAC_BITS),
    .IW(IW)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i      (cmd),
    .addr_i     (addr),
    .in_item_i,
    .out_ready_i,
    .status_o   (status),
    .z_in_o     (z_in),
    .out_valid_o,
    .out_item_o
  );

endmodule

### rtl/prc_datapath.sv
`timescale 1ns / 1ps

module prc_datapath import prc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned FRAC_BITS   = 4,
  parameter int unsigned IW          = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  logic [IW-1:0] addr_i,
  input  in_item_t      in_item_i,
  input  logic          out_ready_i,
  output status_t       status_o,
  output logic          z_in_o,
  output logic          out_valid_o,
  output out_item_t     out_item_o
);

  localparam int unsigned K = 2 * FRAC_BITS + 1;
  localparam logic [AREA_W-1:0] HALF = AREA_W'(1) << (K - 1);

  entry_t             mem [MAX_REGIONS];
  entry_t             ent_q;
  logic signed [15:0] px_q, py_q, pz_q;
  logic [7:0]         found_q;
  logic [1:0]         zone_q;
  logic signed [33:0] prod1_q, prod2_q;
  logic [AREA_W-1:0]  whole_q, parts_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic signed [16:0] ux, uy, vx, vy;
  logic [34:0]        cr_diff, cr_abs;
  logic [AREA_W-1:0]  whole_rnd, parts_rnd;
  logic               wr_ok;

  assign wr_ok = 32'(in_item_i.entry) < MAX_REGIONS;

  // Table write on a load transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && wr_ok) begin
      mem[IW'(in_item_i.entry)] <= '{id: in_item_i.region_id,
                                     ax: in_item_i.ax, ay: in_item_i.ay, az: in_item_i.az,
                                     bx: in_item_i.bx, by: in_item_i.by, bz: in_item_i.bz,
                                     cx: in_item_i.cx, cy: in_item_i.cy};
    end
  end

  // Registered table read
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      ent_q <= mem[addr_i];
    end
  end

  // Hold the point
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_item_i.ax;
      py_q <= in_item_i.ay;
      pz_q <= in_item_i.az;
    end
  end

  // Edge vectors for the selected cross product
  always_comb begin
    ux = '0; uy = '0; vx = '0; vy = '0;
    case (cmd_i.mul_sel)
      2'd0: begin
        ux = 17'(ent_q.bx) - 17'(ent_q.ax); uy = 17'(ent_q.by) - 17'(ent_q.ay);
        vx = 17'(ent_q.cx) - 17'(ent_q.ax); vy = 17'(ent_q.cy) - 17'(ent_q.ay);
      end
      2'd1: begin
        ux = 17'(ent_q.bx) - 17'(px_q); uy = 17'(ent_q.by) - 17'(py_q);
        vx = 17'(ent_q.cx) - 17'(px_q); vy = 17'(ent_q.cy) - 17'(py_q);
      end
      2'd2: begin
        ux = 17'(px_q) - 17'(ent_q.ax); uy = 17'(py_q) - 17'(ent_q.ay);
        vx = 17'(ent_q.cx) - 17'(ent_q.ax); vy = 17'(ent_q.cy) - 17'(ent_q.ay);
      end
      default: begin
        ux = 17'(ent_q.bx) - 17'(ent_q.ax); uy = 17'(ent_q.by) - 17'(ent_q.ay);
        vx = 17'(px_q) - 17'(ent_q.ax); vy = 17'(py_q) - 17'(ent_q.ay);
      end
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod1_q <= ux * vy;
      prod2_q <= uy * vx;
    end
  end

  // Magnitude of the doubled area
  assign cr_diff = {prod1_q[33], prod1_q} - {prod2_q[33], prod2_q};
  assign cr_abs  = cr_diff[34] ? (35'd0 - cr_diff) : cr_diff;

  // Accumulate whole and partial areas
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      if (cmd_i.acc_sel == 2'd0) begin
        whole_q <= AREA_W'(cr_abs);
      end else if (cmd_i.acc_sel == 2'd1) begin
        parts_q <= AREA_W'(cr_abs);
      end else begin
        parts_q <= parts_q + AREA_W'(cr_abs);
      end
    end
  end

  assign whole_rnd = (whole_q + HALF) >> K;
  assign parts_rnd = (parts_q + HALF) >> K;

  // Per-point result
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      found_q <= '0;
      zone_q  <= ZONE_NONE;
    end else begin
      if (cmd_i.set_found) found_q <= ent_q.id;
      if (cmd_i.set_zone)  zone_q  <= status_o.zone_hit ? ZONE_IN : ZONE_OUT;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.found_region <= found_q;
      out_q.zone         <= zone_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    status_o.is_box   = ent_q.id < ID_TRI_MIN;
    status_o.box_hit  = px_q >= ent_q.ax && px_q <= ent_q.bx &&
                        py_q >= ent_q.ay && py_q <= ent_q.by;
    status_o.zone_hit = px_q > ent_q.ax && px_q < ent_q.bx &&
                        py_q > ent_q.ay && py_q < ent_q.by;
    status_o.tri_hit  = whole_rnd == parts_rnd;
    status_o.out_busy = out_valid_q && !out_ready_i;
  end

  // z bounds for 3D boxes fold into the box test
  assign z_in_o = pz_q >= ent_q.az && pz_q <= ent_q.bz;

endmodule

### rtl/prc_ctrl.sv
`timescale 1ns / 1ps

module prc_ctrl import prc_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 16,
  parameter int unsigned IW          = 4,
  parameter int unsigned CW          = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_kind_i,
  output logic                 in_ready_o,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  status_t              status_i,
  input  logic                 z_in_i,
  output cmd_t                 cmd_o,
  output logic [IW-1:0]        addr_o
);

  state_e         state_q, state_d;
  logic [CW-1:0]  idx_q, n;
  logic [2:0]     step_q;
  logic           three_d_q;
  logic [4:0]     count_q;
  logic           accept, last, hit3;

  assign accept = in_valid_i && in_ready_o;
  assign n      = (32'(count_q) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(count_q);
  assign last   = ({1'b0, idx_q} + 1'b1) == {1'b0, n};
  assign addr_o = idx_q[IW-1:0];
  assign hit3   = status_i.is_box && status_i.box_hit && z_in_i;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      three_d_q <= 1'b0;
      count_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_THREE_D: three_d_q <= cfg_data_i[0];
        REG_COUNT:   count_q   <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && in_kind_i == KIND_POINT) begin
          state_d = (n == '0) ? ST_DONE : ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_TEST;
      ST_TEST: begin
        if (three_d_q) begin
          state_d = (hit3 || last) ? ST_DONE : ST_FETCH;
        end else if (status_i.is_box && idx_q == '0) begin
          state_d = last ? ST_DONE : ST_FETCH;
        end else if (status_i.is_box) begin
          state_d = (status_i.box_hit || last) ? ST_DONE : ST_FETCH;
        end else begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = (step_q == 3'd4) ? ST_CMP : ST_MUL;
      ST_CMP:  state_d = (status_i.tri_hit || last) ? ST_DONE : ST_FETCH;
      ST_DONE: state_d = status_i.out_busy ? ST_DONE : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    cmd_o.mul_sel = step_q[1:0];
    cmd_o.acc_sel = 2'(step_q - 3'd1);
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_wr = accept && in_kind_i == KIND_LOAD;
        cmd_o.start   = accept && in_kind_i == KIND_POINT;
      end
      ST_FETCH: cmd_o.rd_en = 1'b1;
      ST_TEST: begin
        if (three_d_q) begin
          cmd_o.set_found = hit3;
        end else if (status_i.is_box && idx_q == '0) begin
          cmd_o.set_zone = 1'b1;
        end else if (status_i.is_box) begin
          cmd_o.set_found = status_i.box_hit;
        end
      end
      ST_MUL: begin
        cmd_o.mul_en = step_q != 3'd4;
        cmd_o.acc_en = step_q != 3'd0;
      end
      ST_CMP:  cmd_o.set_found = status_i.tri_hit;
      ST_DONE: cmd_o.publish = !status_i.out_busy;
      default: ;
    endcase
  end

  // State, entry index and multiply step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE) begin
        idx_q <= '0;
      end else if ((state_q == ST_TEST || state_q == ST_CMP) && state_d == ST_FETCH) begin
        idx_q <= idx_q + 1'b1;
      end
      if (state_q == ST_MUL) begin
        step_q <= step_q + 3'd1;
      end else begin
        step_q <= '0;
      end
    end
  end

endmodule

### tb/sv/tb_point_region_classifier_top.sv
`timescale 1ns / 1ps

module tb_point_region_classifier_top;
  import prc_pkg::*;

  localparam int unsigned NSLOT  = 16;
  localparam int unsigned FRAC   = 4;
  localparam int unsigned RND_K  = 2 * FRAC + 1;
  localparam int unsigned SETTLE = 8 * NSLOT + 8;
  localparam int unsigned IN_W   = $bits(in_item_t);
  localparam longint      LIMIT  = 3000000;

  typedef enum logic { ROW_SEND, ROW_CFG } row_op_e;

  typedef struct {
    row_op_e   op;
    in_item_t  it;
    bit        typed;
    out_item_t res;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_DAT_W-1:0] dat;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t  in_item;
  out_item_t out_item;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  // Predictor state
  entry_t    region_tbl[NSLOT];
  bit        mode_3d;
  int        count_reg;
  out_item_t result_q[$];

  int     send_idle_pct, recv_stall_pct;
  bit     hold_req, hold_done;
  int     hold_cnt;
  int     mismatches, results_seen, points_sent, loads_sent;
  longint cycles;
  row_t   dir_rows[$];

  point_region_classifier_top uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Doubled triangle area, exact in raw units
  function automatic longint twice_area(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
    longint c;
    c = px * (qy - ry) + qx * (ry - py) + rx * (py - qy);
    return (c < 0) ? -c : c;
  endfunction

  function automatic longint round_half_up(longint n);
    return (n + (longint'(1) << (RND_K - 1))) >>> RND_K;
  endfunction

  // Walk the region table in order; first hit wins
  function automatic out_item_t classify_point(in_item_t p);
    out_item_t r;
    entry_t    e;
    int        n;
    longint    whole, parts;
    r.found_region = 8'd0;
    r.zone = ZONE_NONE;
    n = (count_reg > NSLOT) ? NSLOT : count_reg;
    for (int i = 0; i < n; i++) begin
      e = region_tbl[i];
      if (mode_3d) begin
        if (e.id < ID_TRI_MIN && p.ax >= e.ax && p.ax <= e.bx && p.ay >= e.ay &&
            p.ay <= e.by && p.az >= e.az && p.az <= e.bz) begin
          r.found_region = e.id;
          break;
        end
      end else if (e.id < ID_TRI_MIN && i == 0) begin
        r.zone = (p.ax > e.ax && p.ax < e.bx && p.ay > e.ay && p.ay < e.by) ?
                 ZONE_IN : ZONE_OUT;
      end else if (e.id < ID_TRI_MIN) begin
        if (p.ax >= e.ax && p.ax <= e.bx && p.ay >= e.ay && p.ay <= e.by) begin
          r.found_region = e.id;
          break;
        end
      end else begin
        whole = twice_area(e.ax, e.ay, e.bx, e.by, e.cx, e.cy);
        parts = twice_area(p.ax, p.ay, e.bx, e.by, e.cx, e.cy) +
                twice_area(e.ax, e.ay, p.ax, p.ay, e.cx, e.cy) +
                twice_area(e.ax, e.ay, e.bx, e.by, p.ax, p.ay);
        if (round_half_up(whole) == round_half_up(parts)) begin
          r.found_region = e.id;
          break;
        end
      end
    end
    return r;
  endfunction

  // Update predictor state for an accepted item and queue its result
  function automatic void track_item(in_item_t it, bit typed, out_item_t res);
    if (it.kind == KIND_LOAD) begin
      region_tbl[it.entry] = '{it.region_id, it.ax, it.ay, it.az, it.bx, it.by,
                               it.bz, it.cx, it.cy};
      loads_sent++;
    end else begin
      result_q.push_back(typed ? res : classify_point(it));
      points_sent++;
    end
  endfunction

  // Offer one item; entered and left at a falling edge, valid left as is
  task automatic send_item(in_item_t it, bit typed = 0, out_item_t res = '0);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    track_item(it, typed, res);
    @(negedge clk);
  endtask

  // Let the block go idle before touching configuration
  task automatic drain();
    in_valid <= 1'b0;
    wait (result_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] dat);
    in_valid  <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= dat;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_THREE_D) mode_3d = dat[0];
    else count_reg = dat;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rnd_coord();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(4095)) - 2048);
  endfunction

  function automatic in_item_t rnd_load(int slot, bit want_box);
    in_item_t it;
    int lo, span;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    it.kind  = KIND_LOAD;
    it.entry = 4'(slot);
    if (want_box) begin
      it.region_id = 8'($urandom_range(9));
      lo = $signed(rnd_coord()); span = $urandom_range(1200);
      it.ax = 16'(lo); it.bx = (lo + span > 32767) ? 16'sd32767 : 16'(lo + span);
      lo = $signed(rnd_coord()); span = $urandom_range(1200);
      it.ay = 16'(lo); it.by = (lo + span > 32767) ? 16'sd32767 : 16'(lo + span);
      lo = $signed(rnd_coord()); span = $urandom_range(1200);
      it.az = 16'(lo); it.bz = (lo + span > 32767) ? 16'sd32767 : 16'(lo + span);
      // occasionally an inverted or fully random box
      if ($urandom_range(9) == 0) begin
        it.ax = 16'($urandom); it.bx = 16'($urandom);
      end
    end else begin
      it.region_id = 8'($urandom_range(255, 10));
      it.ax = rnd_coord(); it.ay = rnd_coord();
      it.bx = rnd_coord(); it.by = rnd_coord();
      it.cx = rnd_coord(); it.cy = rnd_coord();
    end
    return it;
  endfunction

  // Points mostly aimed at a loaded region so hits are common
  function automatic in_item_t rnd_point();
    in_item_t it;
    entry_t   e;
    int       n, jx, jy;
    it = in_item_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    it.kind = KIND_POINT;
    n = (count_reg > NSLOT) ? NSLOT : count_reg;
    if (n > 0 && $urandom_range(9) < 7) begin
      e  = region_tbl[$urandom_range(n - 1)];
      jx = $signed($urandom_range(8)) - 4;
      jy = $signed($urandom_range(8)) - 4;
      case ($urandom_range(3))
        0: begin it.ax = e.ax; it.ay = e.ay; it.az = e.az; end
        1: begin it.ax = e.bx; it.ay = e.by; it.az = e.bz; end
        2: begin
          it.ax = 16'((e.ax + e.bx + e.cx) / 3 + jx);
          it.ay = 16'((e.ay + e.by + e.cy) / 3 + jy);
          it.az = 16'((e.az + e.bz) / 2);
        end
        default: begin
          it.ax = 16'((e.ax + e.bx) / 2 + jx);
          it.ay = 16'((e.ay + e.by) / 2 + jy);
          it.az = 16'((e.az + e.bz) / 2 + jx);
        end
      endcase
    end else if ($urandom_range(1) == 0) begin
      it.ax = rnd_coord(); it.ay = rnd_coord(); it.az = rnd_coord();
    end
    return it;
  endfunction

  function automatic row_t mk_load(int slot, int id, int ax, int ay, int az,
                                   int bx, int by, int bz, int cx, int cy);
    row_t r;
    r = '{op: ROW_SEND, typed: 0, default: '0};
    r.it = '{KIND_LOAD, 4'(slot), 8'(id), 16'(ax), 16'(ay), 16'(az), 16'(bx),
             16'(by), 16'(bz), 16'(cx), 16'(cy)};
    return r;
  endfunction

  function automatic row_t mk_point(int x, int y, int z, bit typed = 0,
                                    int found = 0, logic [1:0] zn = ZONE_NONE);
    row_t r;
    r = '{op: ROW_SEND, default: '0};
    r.it = '{KIND_POINT, 4'd0, 8'd0, 16'(x), 16'(y), 16'(z), 16'd0, 16'd0,
             16'd0, 16'd0, 16'd0};
    r.typed = typed;
    r.res   = '{8'(found), zn};
    return r;
  endfunction

  function automatic row_t mk_cfg(logic [CFG_IDX_W-1:0] idx, int dat);
    row_t r;
    r = '{op: ROW_CFG, default: '0};
    r.idx = idx;
    r.dat = CFG_DAT_W'(dat);
    return r;
  endfunction

  // Receiver ready, with one long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt  <= 400;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result with none expected: region %0d zone %0d",
                   out_item.found_region, out_item.zone);
      end else begin
        want = result_q.pop_front();
        if (out_item.found_region !== want.found_region || out_item.zone !== want.zone)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d: expected region %0d zone %0d, got %0d zone %0d",
                     results_seen, want.found_region, want.zone,
                     out_item.found_region, out_item.zone);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("point_region_classifier_top test failed");
      $finish;
    end
  end

  initial begin
    int idle_tbl[4], stall_tbl[4];
    int phase, n_items;
    idle_tbl  = '{0, 58, 0, 37};
    stall_tbl = '{0, 0, 58, 37};
    rst_n = 1'b0; in_valid = 1'b0; in_item = '0; out_ready = 1'b0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    hold_req = 0; hold_done = 0; hold_cnt = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    mode_3d = 0; count_reg = 0;
    mismatches = 0; results_seen = 0; points_sent = 0; loads_sent = 0; cycles = 0;
    foreach (region_tbl[i]) region_tbl[i] = '0;

    // Directed rows: empty table, zone box, triangle, catch-all box, 3D, count 0
    dir_rows = '{
      mk_point(0, 0, 0, 1, 0, ZONE_NONE),
      mk_load(0, 3, -160, -160, 0, 160, 160, 0, 0, 0),
      mk_load(1, 12, -800, -800, 0, 800, -800, 0, 0, 800),
      mk_load(2, 9, -32768, -32768, -32768, 32767, 32767, 32767, 0, 0),
      mk_load(3, 255, 0, 0, 0, 1, 0, 0, 0, 1),
      mk_cfg(REG_COUNT, 4),
      mk_point(0, 0, 0, 1, 12, ZONE_IN),
      mk_point(160, 0, 0, 1, 12, ZONE_OUT),
      mk_point(-32768, -32768, 0, 1, 9, ZONE_OUT),
      mk_point(32767, 32767, 0, 1, 9, ZONE_OUT),
      mk_point(0, -801, 0),
      mk_point(0, -820, 0),
      mk_point(-800, -800, 0),
      mk_cfg(REG_THREE_D, 1),
      mk_point(0, 0, 0, 1, 3, ZONE_NONE),
      mk_point(0, 0, 5, 1, 9, ZONE_NONE),
      mk_point(32767, -32768, 32767, 1, 9, ZONE_NONE),
      mk_cfg(REG_COUNT, 0),
      mk_point(100, 100, 100, 1, 0, ZONE_NONE),
      mk_cfg(REG_THREE_D, 0)
    };

    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == ROW_CFG) begin
        drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].dat);
      end else begin
        send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    // Random phases: four idling patterns, each with two settings
    for (phase = 0; phase < 8; phase++) begin
      drain();
      send_idle_pct  = idle_tbl[phase / 2];
      recv_stall_pct = stall_tbl[phase / 2];
      cfg_write(REG_THREE_D, CFG_DAT_W'(phase % 2));
      for (int s = 0; s < NSLOT; s++)
        send_item(rnd_load(s, (phase % 2 == 1) ? ($urandom_range(9) != 0)
                                                : ($urandom_range(1) == 0)));
      case (phase)
        0:       cfg_write(REG_COUNT, CFG_DAT_W'(NSLOT));
        1:       cfg_write(REG_COUNT, CFG_DAT_W'(31));
        2:       cfg_write(REG_COUNT, CFG_DAT_W'(1));
        default: cfg_write(REG_COUNT, CFG_DAT_W'($urandom_range(NSLOT, 2)));
      endcase
      if (phase == 1) hold_req = 1;
      n_items = 190;
      for (int k = 0; k < n_items; k++) begin
        if ($urandom_range(3) == 0)
          send_item(rnd_load($urandom_range(NSLOT - 1), $urandom_range(1)));
        else
          send_item(rnd_point());
      end
    end

    drain();
    $display("Ran %0d point classifications and %0d table loads, %0d results checked,",
             points_sent, loads_sent, results_seen);
    $display("over 2D and 3D modes, counts 0 to 31, with idle, stall and hold-off phases.");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("point_region_classifier_top test passed");
    end else begin
      $display("point_region_classifier_top test failed");
    end
    $finish;
  end

endmodule
